[hdl/cbs_pkg.sv]
package cbs_pkg;

    // Field widths of the stream and register ports
    localparam int CW        = 24;           // one coordinate, Q8.16
    localparam int TW        = 16;           // curve parameter, Q0.16
    localparam int IN_DATA_W = 3 * CW + TW;  // 88 bits, whole bytes
    localparam int OUT_DATA_W = 12 * CW;     // 288 bits, whole bytes
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Shared multiplier and accumulator widths
    localparam int MA_W  = 36;               // basis weight at scale 2^32
    localparam int MB_W  = 27;
    localparam int MP_W  = MA_W + MB_W;
    localparam int ACC_W = 62;

    // Register map and reset value
    localparam logic [0:0]  REG_FACTOR    = 1'b0;
    localparam logic [15:0] FACTOR_RESET  = 16'd6554;

    // Item kinds carried on tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [2:0] LOADED_FULL = 3'd4;

    // Sequencer step limits
    localparam logic [5:0] POW_LAST   = 6'd4;
    localparam logic [5:0] SUM_ISSUE  = 6'd36;
    localparam logic [5:0] SUM_LAST   = 6'd38;
    localparam logic [5:0] POST_LAST  = 6'd6;
    localparam logic [2:0] POST_DIVS  = 3'd3;

    // Reciprocal of 3 at scale 2^27, exact for inputs below 2^26
    localparam logic [MB_W-1:0] RECIP3 = 27'd44739243;

    // Limits of the point sum (after the 2^32 shift) that divide into 24 bits
    localparam logic signed [29:0] PNT_HI   = 30'sd50331647;
    localparam logic signed [29:0] PNT_LO   = -30'sd50331648;
    localparam logic signed [28:0] PNT_BIAS = 29'sd25165824;

    localparam logic signed [MA_W-1:0] ONE_W = 36'sh1_0000_0000;

    typedef logic signed [CW-1:0] t_coord;

    typedef enum logic [1:0] {
        KIND_PNT = 2'd0,
        KIND_TAN = 2'd1,
        KIND_ACC = 2'd2
    } t_kind;

    // Tag that travels with a product through the multiply-accumulate stages
    typedef struct packed {
        logic       vld;
        logic       last;
        t_kind      kind;
        logic [1:0] ch;
    } t_tag;

    function automatic t_coord sat24(input logic signed [29:0] v);
        t_coord res;
        if (v > 30'sd8388607) begin
            res = 24'sh7FFFFF;
        end else if (v < -30'sd8388608) begin
            res = -24'sh800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

endpackage

[hdl/cubic_bspline_evaluator.sv]
// Load item: shifted into the window when accepted, no result.
// Evaluate item: runs the power, sum and post steps on a full window; no item is taken
// until the result is handed on. One shared 36x27 multiplier does 4 power products,
// 36 weight-point products, 3 divides by three and 3 tip scalings, one product per cycle.
// A finished result waits in an output register while the next items are accepted.
// Synchronous active-low reset clears the window and the load count and sets the factor to 6554.
module cubic_bspline_evaluator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // ctrl_x [23:0], ctrl_y [47:24], ctrl_z [71:48], t_value [87:72]
    input  logic [cbs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action [0]
    input  logic [0:0]                     s_axis_tuser,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // point_x/y/z [71:0], tangent_x/y/z [143:72], accel_x/y/z [215:144],
    // tip_x/y/z [287:216], 24 bits each from the lowest bit up
    output logic [cbs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbs_pkg::PADDR_W-1:0]    paddr,
    input  logic [cbs_pkg::PDATA_W-1:0]    pwdata,
    output logic [cbs_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import cbs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_POW  = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_POST = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic [2:0]  r_loaded;
    logic [15:0] r_factor;
    t_coord      r_win [12];
    logic [15:0] r_u;

    // powers of t and rounded cubic terms, scale 2^32
    logic [31:0]             r_a;
    logic [33:0]             r_a3;
    logic [33:0]             r_b3;
    logic signed [MA_W-1:0]  r_r1, r_rm1, r_r3, r_rm3;

    // multiply-accumulate pipeline
    logic signed [MA_W-1:0]  r_w;
    t_coord                  r_pt;
    t_tag                    r_t1, r_t2, r_t3;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  r_prod;
    logic signed [ACC_W-1:0] r_acc, r_sum;

    // per-channel results
    logic [25:0] r_divx [3];
    logic [2:0]  r_phi, r_plo;
    t_coord      r_tg [3];
    t_coord      r_ac [3];
    t_coord      r_pnt [3];
    t_coord      r_tip [3];

    logic                  r_ovld;
    logic [OUT_DATA_W-1:0] r_odata;

    logic in_acc, out_take, cfg_wr, out_load;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign out_take      = m_axis_tvalid & m_axis_tready;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign out_load      = (r_state == ST_DONE) && (!r_ovld || out_take);

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_FACTOR);
    assign prdata = (paddr[2] == REG_FACTOR) ? {16'd0, r_factor} : '0;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && s_axis_tuser[0] == ACT_EVAL && r_loaded == LOADED_FULL) begin
                    n_state = ST_POW;
                    n_cnt   = '0;
                end
            end
            ST_POW: begin
                if (r_cnt == POW_LAST) begin
                    n_state = ST_SUM;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_SUM: begin
                if (r_cnt == SUM_LAST) begin
                    n_state = ST_POST;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_POST: begin
                if (r_cnt == POST_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // decode the issue step: point j, group of (channel, kind)
    logic [1:0] iss_j, iss_ch;
    t_kind      iss_kind;
    logic       iss_vld;
    logic [3:0] win_idx;

    assign iss_j   = r_cnt[1:0];
    assign iss_vld = (r_state == ST_SUM) && (r_cnt < SUM_ISSUE);
    assign win_idx = {1'b0, iss_j, 1'b0} + {2'b00, iss_j} + {2'b00, iss_ch};

    always_comb begin
        unique case (r_cnt[5:2])
            4'd0:    begin iss_ch = 2'd0; iss_kind = KIND_PNT; end
            4'd1:    begin iss_ch = 2'd0; iss_kind = KIND_TAN; end
            4'd2:    begin iss_ch = 2'd0; iss_kind = KIND_ACC; end
            4'd3:    begin iss_ch = 2'd1; iss_kind = KIND_PNT; end
            4'd4:    begin iss_ch = 2'd1; iss_kind = KIND_TAN; end
            4'd5:    begin iss_ch = 2'd1; iss_kind = KIND_ACC; end
            4'd6:    begin iss_ch = 2'd2; iss_kind = KIND_PNT; end
            4'd7:    begin iss_ch = 2'd2; iss_kind = KIND_TAN; end
            4'd8:    begin iss_ch = 2'd2; iss_kind = KIND_ACC; end
            default: begin iss_ch = 2'd0; iss_kind = KIND_PNT; end
        endcase
    end

    // basis weight at scale 2^32 from the stored powers
    logic signed [MA_W-1:0] w_a, w_a3, w_b, w_b3;
    logic signed [MA_W-1:0] wx, wy, wz, wk;

    assign w_a  = {4'd0, r_a};
    assign w_a3 = {2'd0, r_a3};
    assign w_b  = {4'd0, r_u, 16'd0};
    assign w_b3 = {2'd0, r_b3};

    always_comb begin
        wx = '0;
        wy = '0;
        wz = '0;
        wk = '0;
        case (iss_kind)
            KIND_PNT: begin
                case (iss_j)
                    2'd0: begin wx = r_rm1; wy = w_a3; wz = -w_b3; wk = ONE_W; end
                    2'd1: begin wx = r_r3; wy = -(w_a3 <<< 1); wk = ONE_W <<< 2; end
                    2'd2: begin wx = r_rm3; wy = w_a3; wz = w_b3; wk = ONE_W; end
                    default: wx = r_r1;
                endcase
            end
            KIND_TAN: begin
                case (iss_j)
                    2'd0: begin wx = -w_a; wy = w_b <<< 1; wk = -ONE_W; end
                    2'd1: begin wx = w_a3; wy = -(w_b <<< 2); end
                    2'd2: begin wx = -w_a3; wy = w_b <<< 1; wk = ONE_W; end
                    default: wx = w_a;
                endcase
            end
            default: begin
                case (iss_j)
                    2'd0: begin wx = -w_b; wk = ONE_W; end
                    2'd1: begin wx = w_b3; wk = -(ONE_W <<< 1); end
                    2'd2: begin wx = -w_b3; wk = ONE_W; end
                    default: wx = w_b;
                endcase
            end
        endcase
    end

    // post steps: three divides by three, then three tip products
    logic [2:0] pn, cm;
    logic [1:0] pch, cch;
    logic [17:0] u3x;

    assign pn  = r_cnt[2:0];
    assign cm  = r_cnt[2:0] - 3'd1;
    assign pch = (pn < POST_DIVS) ? pn[1:0] : 2'(pn - POST_DIVS);
    assign cch = (cm < POST_DIVS) ? cm[1:0] : 2'(cm - POST_DIVS);
    assign u3x = {1'b0, r_u, 1'b0} + {2'b00, r_u};

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_POW: begin
                case (r_cnt[2:0])
                    3'd1:    begin mul_a = {20'd0, r_u}; mul_b = {9'd0, u3x}; end
                    3'd2:    begin mul_a = {4'd0, r_a};  mul_b = {11'd0, r_u}; end
                    3'd3:    begin mul_a = {4'd0, r_a};  mul_b = {9'd0, r_b3[33:16]}; end
                    default: begin mul_a = {20'd0, r_u}; mul_b = {11'd0, r_u}; end
                endcase
            end
            ST_POST: begin
                if (pn < POST_DIVS) begin
                    mul_a = {10'd0, r_divx[pch]};
                    mul_b = RECIP3;
                end else begin
                    mul_a = {{12{r_tg[pch][23]}}, r_tg[pch]};
                    mul_b = {11'd0, r_factor};
                end
            end
            default: begin
                mul_a = r_w;
                mul_b = {{3{r_pt[23]}}, r_pt};
            end
        endcase
    end

    // rounding of the cubic terms
    logic [48:0] pw_u3p;
    logic [49:0] pw_u3n;
    logic [50:0] pw_v3p, pw_v3n;

    assign pw_u3p = {1'b0, r_prod[47:0]} + 49'd32768;
    assign pw_u3n = 50'd32768 - {2'b00, r_prod[47:0]};
    assign pw_v3p = {1'b0, r_prod[49:0]} + 51'd32768;
    assign pw_v3n = 51'd32768 - {1'b0, r_prod[49:0]};

    // accumulate and group reduction
    logic signed [ACC_W-1:0] acc_nxt, rnd_c, f_sum;
    logic signed [29:0]      pa;
    logic [28:0]             px;

    assign acc_nxt = r_acc + r_prod[ACC_W-1:0];

    always_comb begin
        case (r_t3.kind)
            KIND_PNT: rnd_c = 62'sd3 <<< 32;
            KIND_TAN: rnd_c = 62'sd1 <<< 32;
            default:  rnd_c = 62'sd1 <<< 31;
        endcase
    end

    assign f_sum = r_sum + rnd_c;
    assign pa    = f_sum[61:32];
    assign px    = f_sum[61:33] + PNT_BIAS;

    // post captures: quotient and tip
    logic [23:0]        q3;
    t_coord             pnt_v;
    logic [39:0]        tp;
    logic signed [29:0] tip_s;

    assign q3 = r_prod[50:27];

    always_comb begin
        if (r_phi[cch]) begin
            pnt_v = 24'sh7FFFFF;
        end else if (r_plo[cch]) begin
            pnt_v = -24'sh800000;
        end else begin
            pnt_v = {~q3[23], q3[22:0]};
        end
    end

    assign tp    = r_prod[39:0] + 40'd32768;
    assign tip_s = {{6{r_pnt[cch][23]}}, r_pnt[cch]} + {{6{tp[39]}}, tp[39:16]};

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_loaded <= '0;
            r_factor <= FACTOR_RESET;
            r_t1     <= '0;
            r_t2     <= '0;
            r_t3     <= '0;
            r_ovld   <= 1'b0;
            for (int i = 0; i < 12; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (cfg_wr) begin
                r_factor <= pwdata[15:0];
            end
            // shift a control point into the window
            if (in_acc && s_axis_tuser[0] == ACT_LOAD) begin
                for (int i = 0; i < 9; i++) begin
                    r_win[i] <= r_win[i + 3];
                end
                r_win[9]  <= s_axis_tdata[23:0];
                r_win[10] <= s_axis_tdata[47:24];
                r_win[11] <= s_axis_tdata[71:48];
                if (r_loaded != LOADED_FULL) begin
                    r_loaded <= r_loaded + 3'd1;
                end
            end
            // advance the product tags
            r_t1.vld  <= iss_vld;
            r_t1.last <= (iss_j == 2'd3);
            r_t1.kind <= iss_kind;
            r_t1.ch   <= iss_ch;
            r_t2      <= r_t1;
            r_t3.vld  <= r_t2.vld & r_t2.last;
            r_t3.last <= r_t2.last;
            r_t3.kind <= r_t2.kind;
            r_t3.ch   <= r_t2.ch;
            // hold the result until it is taken
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (out_take) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (in_acc && s_axis_tuser[0] == ACT_EVAL) begin
            r_u <= s_axis_tdata[87:72];
        end

        // powers of t
        if (r_state == ST_POW) begin
            r_acc <= '0;
            case (r_cnt[2:0])
                3'd1: begin
                    r_a  <= r_prod[31:0];
                    r_b3 <= {u3x, 16'd0};
                end
                3'd2: r_a3 <= r_prod[33:0];
                3'd3: begin
                    r_r1  <= {3'd0, pw_u3p[48:16]};
                    r_rm1 <= {{2{pw_u3n[49]}}, pw_u3n[49:16]};
                end
                3'd4: begin
                    r_r3  <= {1'b0, pw_v3p[50:16]};
                    r_rm3 <= {pw_v3n[50], pw_v3n[50:16]};
                end
                default: ;
            endcase
        end

        // weight and point for the next product
        r_w  <= wx + wy + wz + wk;
        r_pt <= r_win[win_idx];

        // accumulate four products per group
        if (r_t2.vld) begin
            if (r_t2.last) begin
                r_sum <= acc_nxt;
                r_acc <= '0;
            end else begin
                r_acc <= acc_nxt;
            end
        end

        // reduce a finished group
        if (r_t3.vld) begin
            case (r_t3.kind)
                KIND_PNT: begin
                    r_divx[r_t3.ch] <= px[25:0];
                    r_phi[r_t3.ch]  <= (pa > PNT_HI);
                    r_plo[r_t3.ch]  <= (pa < PNT_LO);
                end
                KIND_TAN: r_tg[r_t3.ch] <= sat24({f_sum[61], f_sum[61:33]});
                default:  r_ac[r_t3.ch] <= sat24(f_sum[61:32]);
            endcase
        end

        // capture divides and tips
        if (r_state == ST_POST && r_cnt[2:0] != 3'd0) begin
            if (cm < POST_DIVS) begin
                r_pnt[cch] <= pnt_v;
            end else begin
                r_tip[cch] <= sat24(tip_s);
            end
        end

        if (out_load) begin
            r_odata <= {r_tip[2], r_tip[1], r_tip[0], r_ac[2], r_ac[1], r_ac[0],
                        r_tg[2], r_tg[1], r_tg[0], r_pnt[2], r_pnt[1], r_pnt[0]};
        end
    end

    // checks
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser[0] == ACT_LOAD) |=>
        (r_loaded == (($past(r_loaded) == LOADED_FULL) ? LOADED_FULL
                                                       : $past(r_loaded) + 3'd1)))
        else $error("load count did not advance on a load");

    a_early_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser[0] == ACT_EVAL && r_loaded != LOADED_FULL) |=>
        (r_state == ST_IDLE))
        else $error("evaluate before a full window started work");

    a_mac_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_t2.vld || r_t3.vld) |-> (r_state == ST_SUM))
        else $error("product tag live outside the sum phase");

    a_win_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && s_axis_tuser[0] == ACT_LOAD) |=> ($stable(r_win[0]) && $stable(r_win[11])))
        else $error("window changed without a load");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside the done step");

endmodule
